/* hdl/clkern_pkg.sv */
// Shared constants, codes and types of the center loss kernel.
// Used by the channel interfaces and by every module of the block but clkern_ram.
package clkern_pkg;

   // Default sizes of the center table.
   localparam int NUM_CLASSES_DEF = 16;
   localparam int FEATURE_DIM_DEF = 128;

   // Field widths of the channels.
   localparam int CLASS_W = 5;
   localparam int ELEM_W  = 7;
   localparam int FEAT_W  = 32;
   localparam int DIFF_W  = 33;
   localparam int SQ_W    = 63;
   localparam int RATE_W  = 17;

   // Shared multiplier operand and product widths.
   localparam int MUL_W  = 33;
   localparam int PROD_W = 2 * MUL_W;

   // Width of the rounded update adjustment and of the new center before saturation.
   localparam int ADJ_W = 35;
   localparam int NEWC_W = 36;

   // Rate register limits and reset value (Q1.16).
   localparam logic [RATE_W-1:0] RATE_ONE   = 17'd65536;
   localparam logic [RATE_W-1:0] RATE_RESET = 17'd32768;

   // Largest magnitude whose square still fits below 2^63.
   localparam logic [DIFF_W-1:0] SQRT_LIMIT = 33'd3037000499;
   localparam logic [SQ_W-1:0]   SQ_MAX     = {SQ_W{1'b1}};

   // Rounding offset of one half in Q.16.
   localparam logic [50:0] ROUND_HALF = 51'd32768;

   // Request kinds.
   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_UPDATE = 1'b1;

   // Command to the shared multiplier.
   typedef struct packed {
      logic                    en;
      logic signed [MUL_W-1:0] a;
      logic signed [MUL_W-1:0] b;
   } mul_req_type;

endpackage

/* hdl/clkern_if.sv */
// Valid/ready channel interfaces of the center loss kernel.
// Depends on clkern_pkg for the field widths.
interface clkern_req_if;
   logic                                     valid;
   logic                                     ready;
   logic                                     req_type;
   logic        [clkern_pkg::CLASS_W-1:0]    class_index;
   logic        [clkern_pkg::ELEM_W-1:0]     element_index;
   logic signed [clkern_pkg::FEAT_W-1:0]     feature_value;

   modport source (output valid, req_type, class_index, element_index, feature_value,
                   input ready);
   modport sink   (input valid, req_type, class_index, element_index, feature_value,
                   output ready);
endinterface

interface clkern_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [clkern_pkg::DIFF_W-1:0]     difference;
   logic        [clkern_pkg::SQ_W-1:0]       squared_error;
   logic                                     no_label;
   logic                                     update_done;

   modport source (output valid, difference, squared_error, no_label, update_done,
                   input ready);
   modport sink   (input valid, difference, squared_error, no_label, update_done,
                   output ready);
endinterface

/* hdl/clkern_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module clkern_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read data registered; a read of the address being written returns the old data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/clkern_mul.sv */
// Shared signed multiplier with a registered product.
// Depends on clkern_pkg for the command struct and widths.
module clkern_mul (
   input  logic                                    clock,
   input  clkern_pkg::mul_req_type                 mul_req,
   output logic signed [clkern_pkg::PROD_W-1:0]    prod
);

   logic signed [clkern_pkg::PROD_W-1:0] prod_ff;

   // The product only changes when the sequencer asks for a new one.
   always_ff @(posedge clock) begin
      if (mul_req.en) begin
         prod_ff <= mul_req.a * mul_req.b;
      end
   end

   assign prod = prod_ff;

endmodule

/* hdl/clkern_seq.sv */
// Sequencer and datapath of the center loss kernel: clear pass, sample and update passes.
// Depends on clkern_pkg and the channel interfaces; drives the two table RAMs and the multiplier.
module clkern_seq #(
   parameter int NUM_CLASSES = clkern_pkg::NUM_CLASSES_DEF,
   parameter int FEATURE_DIM = clkern_pkg::FEATURE_DIM_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   clkern_req_if.sink                              req_ch,
   clkern_rsp_if.source                            rsp_ch,
   input  logic [clkern_pkg::RATE_W-1:0]           alpha,
   // Read side shared by both tables.
   output logic [$clog2(NUM_CLASSES*FEATURE_DIM)-1:0] rd_addr,
   input  logic signed [clkern_pkg::FEAT_W-1:0]    cen_rd_data,
   input  logic signed [clkern_pkg::DIFF_W-1:0]    del_rd_data,
   // Center table write.
   output logic                                    cen_wr_en,
   output logic [$clog2(NUM_CLASSES*FEATURE_DIM)-1:0] cen_wr_addr,
   output logic signed [clkern_pkg::FEAT_W-1:0]    cen_wr_data,
   // Delta table write.
   output logic                                    del_wr_en,
   output logic [$clog2(NUM_CLASSES*FEATURE_DIM)-1:0] del_wr_addr,
   output logic signed [clkern_pkg::DIFF_W-1:0]    del_wr_data,
   // Shared multiplier.
   output clkern_pkg::mul_req_type                 mul_req,
   input  logic signed [clkern_pkg::PROD_W-1:0]    prod
);

   localparam int DEPTH  = NUM_CLASSES * FEATURE_DIM;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

   typedef enum logic [10:0] {
      ST_CLEAR = 11'b000_0000_0001,
      ST_IDLE  = 11'b000_0000_0010,
      ST_RD    = 11'b000_0000_0100,
      ST_DIFF  = 11'b000_0000_1000,
      ST_MAG   = 11'b000_0001_0000,
      ST_MUL   = 11'b000_0010_0000,
      ST_URD   = 11'b000_0100_0000,
      ST_UMUL  = 11'b000_1000_0000,
      ST_UADJ  = 11'b001_0000_0000,
      ST_UWR   = 11'b010_0000_0000,
      ST_FIN   = 11'b100_0000_0000
   } state_type;

   // Control registers.
   state_type                               state_ff, state_in;
   logic [ADDR_W-1:0]                       cnt_ff, cnt_in;
   logic                                    rsp_valid_ff, rsp_valid_in;

   // Working registers.
   logic [ADDR_W-1:0]                       addr_ff, addr_in;
   logic signed [clkern_pkg::FEAT_W-1:0]    feat_ff, feat_in;
   logic signed [clkern_pkg::FEAT_W-1:0]    cen_ff, cen_in;
   logic signed [clkern_pkg::DIFF_W-1:0]    diff_ff, diff_in;
   logic [clkern_pkg::FEAT_W-1:0]           mag_ff, mag_in;
   logic                                    sat_ff, sat_in;
   logic                                    sq_use_ff, sq_use_in;
   logic                                    nolabel_ff, nolabel_in;
   logic                                    upd_ff, upd_in;
   logic signed [clkern_pkg::ADJ_W-1:0]     adj_ff, adj_in;

   // Output register.
   logic signed [clkern_pkg::DIFF_W-1:0]    rsp_diff_ff, rsp_diff_in;
   logic [clkern_pkg::SQ_W-1:0]             rsp_sq_ff, rsp_sq_in;
   logic                                    rsp_nolabel_ff, rsp_nolabel_in;
   logic                                    rsp_upd_ff, rsp_upd_in;

   // Intermediate values.
   logic                                    accept;
   logic                                    out_free;
   logic                                    cls_ok;
   logic                                    elem_ok;
   logic [ADDR_W-1:0]                       idx;
   logic signed [clkern_pkg::DIFF_W-1:0]    diff_new;
   logic signed [clkern_pkg::DIFF_W-1:0]    diff_neg;
   logic [clkern_pkg::DIFF_W-1:0]           mag_full;
   logic [50:0]                             rnd;
   logic signed [clkern_pkg::NEWC_W-1:0]    newc;
   logic signed [clkern_pkg::FEAT_W-1:0]    newc_sat;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   // Label and element checks, and the table entry of a sample.
   assign cls_ok  = int'(req_ch.class_index) < NUM_CLASSES;
   assign elem_ok = int'(req_ch.element_index) < FEATURE_DIM;
   assign idx     = ADDR_W'(req_ch.class_index) * ADDR_W'(FEATURE_DIM)
                    + ADDR_W'(req_ch.element_index);

   // Difference of the feature and the stored center.
   assign diff_new = {feat_ff[clkern_pkg::FEAT_W-1], feat_ff}
                     - {cen_rd_data[clkern_pkg::FEAT_W-1], cen_rd_data};
   assign diff_neg = -diff_ff;
   assign mag_full = diff_ff[clkern_pkg::DIFF_W-1] ? diff_neg : diff_ff;

   // Round alpha times delta to Q16.16 with ties toward plus infinity.
   assign rnd = prod[50:0] + clkern_pkg::ROUND_HALF;

   // New center with saturation to the signed 32-bit range.
   assign newc = {{(clkern_pkg::NEWC_W-clkern_pkg::FEAT_W){cen_ff[clkern_pkg::FEAT_W-1]}},
                  cen_ff}
                 - {adj_ff[clkern_pkg::ADJ_W-1], adj_ff};

   always_comb begin
      if (newc[clkern_pkg::NEWC_W-1:clkern_pkg::FEAT_W-1] == '0 ||
          newc[clkern_pkg::NEWC_W-1:clkern_pkg::FEAT_W-1] == '1) begin
         newc_sat = newc[clkern_pkg::FEAT_W-1:0];
      end else if (newc[clkern_pkg::NEWC_W-1]) begin
         newc_sat = {1'b1, {(clkern_pkg::FEAT_W-1){1'b0}}};
      end else begin
         newc_sat = {1'b0, {(clkern_pkg::FEAT_W-1){1'b1}}};
      end
   end

   // Table ports.
   assign rd_addr     = (state_ff == ST_URD) ? cnt_ff : addr_ff;
   assign cen_wr_en   = (state_ff == ST_CLEAR) || (state_ff == ST_UWR);
   assign cen_wr_addr = cnt_ff;
   assign cen_wr_data = (state_ff == ST_UWR) ? newc_sat : '0;
   assign del_wr_en   = (state_ff == ST_CLEAR) || (state_ff == ST_UWR) || (state_ff == ST_MAG);
   assign del_wr_addr = (state_ff == ST_MAG) ? addr_ff : cnt_ff;
   assign del_wr_data = (state_ff == ST_MAG) ? diff_neg : '0;

   // Multiplier operands: the magnitude squared, or alpha times the pending delta.
   always_comb begin
      mul_req.en = (state_ff == ST_MUL) || (state_ff == ST_UMUL);
      if (state_ff == ST_UMUL) begin
         mul_req.a = del_rd_data;
         mul_req.b = {{(clkern_pkg::MUL_W-clkern_pkg::RATE_W){1'b0}}, alpha};
      end else begin
         mul_req.a = {{(clkern_pkg::MUL_W-clkern_pkg::FEAT_W){1'b0}}, mag_ff};
         mul_req.b = {{(clkern_pkg::MUL_W-clkern_pkg::FEAT_W){1'b0}}, mag_ff};
      end
   end

   // Sequencer next state and register updates.
   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      rsp_valid_in   = rsp_valid_ff;
      addr_in        = addr_ff;
      feat_in        = feat_ff;
      cen_in         = cen_ff;
      diff_in        = diff_ff;
      mag_in         = mag_ff;
      sat_in         = sat_ff;
      sq_use_in      = sq_use_ff;
      nolabel_in     = nolabel_ff;
      upd_in         = upd_ff;
      adj_in         = adj_ff;
      rsp_diff_in    = rsp_diff_ff;
      rsp_sq_in      = rsp_sq_ff;
      rsp_nolabel_in = rsp_nolabel_ff;
      rsp_upd_in     = rsp_upd_ff;

      // A waiting result leaves once it is taken.
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_ADDR) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               addr_in    = idx;
               feat_in    = req_ch.feature_value;
               diff_in    = '0;
               sq_use_in  = 1'b0;
               nolabel_in = 1'b0;
               upd_in     = 1'b0;
               cnt_in     = '0;
               if (req_ch.req_type == clkern_pkg::REQ_UPDATE) begin
                  upd_in   = 1'b1;
                  state_in = ST_URD;
               end else if (!cls_ok) begin
                  nolabel_in = 1'b1;
                  state_in   = ST_FIN;
               end else if (!elem_ok) begin
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_RD;
               end
            end
         end
         ST_RD: begin
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            diff_in   = diff_new;
            sq_use_in = 1'b1;
            state_in  = ST_MAG;
         end
         ST_MAG: begin
            mag_in   = mag_full[clkern_pkg::FEAT_W-1:0];
            sat_in   = mag_full > clkern_pkg::SQRT_LIMIT;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_FIN;
         end
         ST_URD: begin
            state_in = ST_UMUL;
         end
         ST_UMUL: begin
            cen_in   = cen_rd_data;
            state_in = ST_UADJ;
         end
         ST_UADJ: begin
            adj_in   = rnd[50:16];
            state_in = ST_UWR;
         end
         ST_UWR: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_ADDR) begin
               cnt_in   = '0;
               state_in = ST_FIN;
            end else begin
               state_in = ST_URD;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_diff_in    = diff_ff;
               rsp_sq_in      = !sq_use_ff ? '0 :
                                sat_ff     ? clkern_pkg::SQ_MAX :
                                             prod[clkern_pkg::SQ_W-1:0];
               rsp_nolabel_in = nolabel_ff;
               rsp_upd_in     = upd_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff        <= addr_in;
      feat_ff        <= feat_in;
      cen_ff         <= cen_in;
      diff_ff        <= diff_in;
      mag_ff         <= mag_in;
      sat_ff         <= sat_in;
      sq_use_ff      <= sq_use_in;
      nolabel_ff     <= nolabel_in;
      upd_ff         <= upd_in;
      adj_ff         <= adj_in;
      rsp_diff_ff    <= rsp_diff_in;
      rsp_sq_ff      <= rsp_sq_in;
      rsp_nolabel_ff <= rsp_nolabel_in;
      rsp_upd_ff     <= rsp_upd_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.difference    = rsp_diff_ff;
   assign rsp_ch.squared_error = rsp_sq_ff;
   assign rsp_ch.no_label      = rsp_nolabel_ff;
   assign rsp_ch.update_done   = rsp_upd_ff;

endmodule

/* hdl/center_loss_kernel.sv */
// Center loss kernel: class center table, pending delta table and the update rate register.
// Depends on clkern_pkg, clkern_if, clkern_ram, clkern_mul and clkern_seq.
//
// After reset the block clears all NUM_CLASSES*FEATURE_DIM entries of both tables (2048 with
// the defaults), one entry per cycle; req_ch.ready stays low during that pass while rate writes
// on the csr port are taken as usual. A sample item keeps the block busy from acceptance to the
// next ready cycle for a read of the center table, the difference, its magnitude, one pass
// through the shared multiplier for the square and the result load. A sample item without a
// label, or with an element index beyond the feature size, goes straight to the result load.
// An update item visits every table entry in turn (read, multiply by the rate, round, write
// back), then loads the result; the tables share a single read address and the block has one
// shared multiplier. A finished result waits in an output register, so the next item is
// accepted while it has not yet been taken.
module center_loss_kernel #(
   parameter int NUM_CLASSES = clkern_pkg::NUM_CLASSES_DEF,
   parameter int FEATURE_DIM = clkern_pkg::FEATURE_DIM_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   clkern_req_if.sink                        req_ch,
   clkern_rsp_if.source                      rsp_ch,
   input  logic                              csr_wr_en,
   input  logic [clkern_pkg::RATE_W-1:0]     csr_wr_data
);

   localparam int DEPTH  = NUM_CLASSES * FEATURE_DIM;
   localparam int ADDR_W = $clog2(DEPTH);

   logic [clkern_pkg::RATE_W-1:0]          rate_ff;
   logic [clkern_pkg::RATE_W-1:0]          alpha;
   logic [ADDR_W-1:0]                      rd_addr;
   logic signed [clkern_pkg::FEAT_W-1:0]   cen_rd_data;
   logic signed [clkern_pkg::DIFF_W-1:0]   del_rd_data;
   logic                                   cen_wr_en;
   logic [ADDR_W-1:0]                      cen_wr_addr;
   logic signed [clkern_pkg::FEAT_W-1:0]   cen_wr_data;
   logic                                   del_wr_en;
   logic [ADDR_W-1:0]                      del_wr_addr;
   logic signed [clkern_pkg::DIFF_W-1:0]   del_wr_data;
   clkern_pkg::mul_req_type                mul_req;
   logic signed [clkern_pkg::PROD_W-1:0]   prod;

   // Update rate register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= clkern_pkg::RATE_RESET;
      end else if (csr_wr_en) begin
         rate_ff <= csr_wr_data;
      end
   end

   // A rate above one is used as one.
   assign alpha = (rate_ff > clkern_pkg::RATE_ONE) ? clkern_pkg::RATE_ONE : rate_ff;

   // Class center table.
   clkern_ram #(
      .WIDTH (clkern_pkg::FEAT_W),
      .DEPTH (DEPTH)
   ) u_cen_ram (
      .clock   (clock),
      .wr_en   (cen_wr_en),
      .wr_addr (cen_wr_addr),
      .wr_data (cen_wr_data),
      .rd_addr (rd_addr),
      .rd_data (cen_rd_data)
   );

   // Pending delta table.
   clkern_ram #(
      .WIDTH (clkern_pkg::DIFF_W),
      .DEPTH (DEPTH)
   ) u_del_ram (
      .clock   (clock),
      .wr_en   (del_wr_en),
      .wr_addr (del_wr_addr),
      .wr_data (del_wr_data),
      .rd_addr (rd_addr),
      .rd_data (del_rd_data)
   );

   // Shared multiplier.
   clkern_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .prod    (prod)
   );

   // Sequencer and datapath.
   clkern_seq #(
      .NUM_CLASSES (NUM_CLASSES),
      .FEATURE_DIM (FEATURE_DIM)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .alpha       (alpha),
      .rd_addr     (rd_addr),
      .cen_rd_data (cen_rd_data),
      .del_rd_data (del_rd_data),
      .cen_wr_en   (cen_wr_en),
      .cen_wr_addr (cen_wr_addr),
      .cen_wr_data (cen_wr_data),
      .del_wr_en   (del_wr_en),
      .del_wr_addr (del_wr_addr),
      .del_wr_data (del_wr_data),
      .mul_req     (mul_req),
      .prod        (prod)
   );

endmodule

/* hdl/clkern_checker.sv */
// Port level checks of the center loss kernel and the bind that attaches them.
// Depends on clkern_pkg for the field widths; sees only the top level's ports.
module clkern_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic signed [clkern_pkg::DIFF_W-1:0]  rsp_difference,
   input logic [clkern_pkg::SQ_W-1:0]           rsp_squared_error,
   input logic                                  rsp_no_label,
   input logic                                  rsp_update_done
);

   // The block is busy in the cycle after reset, while the tables are cleared.
   a_busy_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("ready high right after reset");

   // An accepted item always keeps the block busy, so ready is low once it has been accepted.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready high right after an accepted item");

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_difference) &&
                                     $stable(rsp_squared_error) &&
                                     $stable(rsp_no_label) && $stable(rsp_update_done)))
      else $error("stalled result changed");

   // Flag items carry no arithmetic and never both flags.
   a_flag_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_no_label || rsp_update_done)) |->
         (!(rsp_no_label && rsp_update_done) && rsp_difference == '0 &&
          rsp_squared_error == '0))
      else $error("flagged result carries data");

   // The square is zero exactly when the difference is zero.
   a_square_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_difference == '0) == (rsp_squared_error == '0)))
      else $error("square does not match difference");

endmodule

bind center_loss_kernel clkern_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_difference    (rsp_ch.difference),
   .rsp_squared_error (rsp_ch.squared_error),
   .rsp_no_label      (rsp_ch.no_label),
   .rsp_update_done   (rsp_ch.update_done)
);
